>>> hw/rtl/rkm_pkg.sv
// ----------------------------------------------------------------------------
// rkm_pkg: shared types and constants for the Rabin-Karp match unit
// Byte and register index types, cell control/status structs, mod-3 helper.
// ----------------------------------------------------------------------------
`default_nettype none

package rkm_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [1:0] cfg_index_t;
    typedef logic [63:0] cfg_data_t;
    typedef logic [4:0] cfg_len_t;
    typedef logic [1:0] digit_t;

    // Register map
    localparam cfg_index_t CFG_PATTERN_LENGTH = 2'd0;
    localparam cfg_index_t CFG_PATTERN_LOW    = 2'd1;
    localparam cfg_index_t CFG_PATTERN_HIGH   = 2'd2;

    localparam int BYTES_PER_REG = 8;
    localparam int PATTERN_BYTES = 2 * BYTES_PER_REG;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Per-cell compare results
    typedef struct packed {
        logic digit_ok;
        logic byte_eq;
    } cell_stat_t;

    // Byte mod 3: each bit pair is worth its value mod 3 since 4 = 1 (mod 3)
    function automatic digit_t mod3(input byte_t b);
        logic [3:0] s;
        s = 4'(b[1:0]) + 4'(b[3:2]) + 4'(b[5:4]) + 4'(b[7:6]);
        if (s >= 4'd9)
        begin
            s = s - 4'd9;
        end
        if (s >= 4'd6)
        begin
            s = s - 4'd6;
        end
        if (s >= 4'd3)
        begin
            s = s - 4'd3;
        end
        return s[1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rkm_if.sv
// ----------------------------------------------------------------------------
// rkm_if: valid/ready channels of the Rabin-Karp match unit
// Text input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rkm_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       start_of_text;

    modport source (output valid, output text_byte, output start_of_text, input ready);
    modport sink   (input valid, input text_byte, input start_of_text, output ready);
endinterface

interface rkm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] compared_position;
    logic        last_of_run;

    modport source (output valid, output compared_position, output last_of_run, input ready);
    modport sink   (input valid, input compared_position, input last_of_run, output ready);
endinterface

interface rkm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rabin_karp_match_positions_unit.sv
// ----------------------------------------------------------------------------
// rabin_karp_match_positions_unit: Rabin-Karp window match position generator
// An accepted byte sets pending_reg; a hash match then sets emitting_reg.
// Throughput: 1 text byte per cycle while hashes differ; a hash match holds
//   input until all N positions (1..length) of its run are loaded for output.
// Position rate is 1 per cycle unless result stalls, set by out_pos_reg and k_reg.
// Reset: window, fill, position and run state clear; pattern length resets to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module rabin_karp_match_positions_unit
    import rkm_pkg::*;
#(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rkm_text_if.sink      text,
    rkm_result_if.source  result,
    rkm_cfg_if.sink       cfg
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // Configuration registers
    cfg_len_t  len_cfg_reg;
    cfg_data_t pat_low_reg;
    cfg_data_t pat_high_reg;

    // Control and payload registers
    logic                     pending_reg;
    logic                     emitting_reg;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         k_next;
    logic [LEN_W-1:0]         fill_reg;
    logic [LEN_W-1:0]         fill_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] run_pos_reg;
    logic [POSITION_BITS-1:0] run_pos_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [POSITION_BITS-1:0] out_pos_reg;
    logic                     out_last_reg;
    logic                     emitting_next;

    logic [LEN_W-1:0]       used_len;
    logic                   in_fire;
    logic                   match_now;
    logic                   load_out;
    logic                   more;
    logic [IDX_W-1:0]       eq_sel;
    byte_t                  pat      [MAX_PATTERN];
    byte_t                  aligned  [MAX_PATTERN];
    byte_t                  cell_dat [MAX_PATTERN];
    cell_ctrl_t             cell_ctl [MAX_PATTERN];
    cell_stat_t             cell_st  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] in_win;
    logic [MAX_PATTERN-1:0] digit_ok_vec;
    logic [MAX_PATTERN-1:0] byte_eq_vec;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg  <= 5'd1;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PATTERN_LENGTH: len_cfg_reg  <= cfg.data[4:0];
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg.data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg.data;
                default:            ;
            endcase
        end
    end

    // Length in use, clamped to 1..MAX_PATTERN
    always_comb
    begin
        if (len_cfg_reg == 5'd0)
        begin
            used_len = LEN_W'(1);
        end
        else if (int'(len_cfg_reg) > MAX_PATTERN)
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = LEN_W'(len_cfg_reg);
        end
    end

    // Handshake
    assign in_fire    = text.valid && text.ready;
    assign match_now  = pending_reg && (fill_reg >= used_len) && (&digit_ok_vec);
    assign text.ready = !emitting_reg && !match_now;

    // Chain of window cells, newest byte at the top end
    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++)
        begin : g_cell
            // Pattern byte j from the registers, zero beyond the sixteenth
            if (j < BYTES_PER_REG)
            begin : g_low
                assign pat[j] = pat_low_reg[8*j +: 8];
            end
            else if (j < PATTERN_BYTES)
            begin : g_high
                assign pat[j] = pat_high_reg[8*(j-BYTES_PER_REG) +: 8];
            end
            else
            begin : g_zero
                assign pat[j] = 8'd0;
            end

            // Pattern byte lined up with this window place
            always_comb
            begin
                aligned[j] = 8'd0;
                for (int l = MAX_PATTERN - j; l <= MAX_PATTERN; l++)
                begin
                    if (used_len == LEN_W'(l))
                    begin
                        aligned[j] = pat[j + l - MAX_PATTERN];
                    end
                end
            end

            assign in_win[j]         = (j + int'(used_len)) >= MAX_PATTERN;
            assign cell_ctl[j].shift = in_fire;
            assign cell_ctl[j].clear = text.start_of_text && (j != MAX_PATTERN - 1);

            if (j == MAX_PATTERN - 1)
            begin : g_top
                rkm_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (cell_ctl[j]),
                    .shift_in     (text.text_byte),
                    .pattern_byte (aligned[j]),
                    .in_window    (in_win[j]),
                    .data         (cell_dat[j]),
                    .stat         (cell_st[j])
                );
            end
            else
            begin : g_mid
                rkm_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (cell_ctl[j]),
                    .shift_in     (cell_dat[j+1]),
                    .pattern_byte (aligned[j]),
                    .in_window    (in_win[j]),
                    .data         (cell_dat[j]),
                    .stat         (cell_st[j])
                );
            end

            assign digit_ok_vec[j] = cell_st[j].digit_ok;
            assign byte_eq_vec[j]  = cell_st[j].byte_eq;
        end
    endgenerate

    // Fill count and text position
    always_comb
    begin
        fill_next = fill_reg;
        pos_next  = pos_reg;
        if (in_fire)
        begin
            fill_next = text.start_of_text ? '0 : fill_reg;
            if (int'(fill_next) < MAX_PATTERN)
            begin
                fill_next = fill_next + LEN_W'(1);
            end
            pos_next = (text.start_of_text ? '0 : pos_reg) + POSITION_BITS'(1);
        end
    end

    // Run sequencing: one compared position per output load
    assign eq_sel   = IDX_W'(MAX_PATTERN - int'(used_len) + int'(k_reg));
    assign more     = ((int'(k_reg) + 1) < int'(used_len)) && byte_eq_vec[eq_sel];
    assign load_out = emitting_reg && (!out_valid_reg || result.ready);

    always_comb
    begin
        emitting_next  = emitting_reg;
        k_next         = k_reg;
        run_pos_next   = run_pos_reg;
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (match_now)
        begin
            emitting_next = 1'b1;
            k_next        = '0;
            run_pos_next  = pos_reg - POSITION_BITS'(used_len) + POSITION_BITS'(1);
        end
        else if (load_out)
        begin
            out_valid_next = 1'b1;
            run_pos_next   = run_pos_reg + POSITION_BITS'(1);
            if (more)
            begin
                k_next = k_reg + IDX_W'(1);
            end
            else
            begin
                emitting_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 1'b0;
            emitting_reg  <= 1'b0;
            k_reg         <= '0;
            fill_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= in_fire;
            emitting_reg  <= emitting_next;
            k_reg         <= k_next;
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        run_pos_reg <= run_pos_next;
        if (load_out)
        begin
            out_pos_reg  <= run_pos_reg;
            out_last_reg <= !more;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.compared_position = 32'(out_pos_reg);
    assign result.last_of_run       = out_last_reg;

    // Checks
    a_k_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        emitting_reg |-> (int'(k_reg) < int'(used_len)))
        else $error("run index beyond pattern length");

    a_match_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        match_now |=> (emitting_reg && !pending_reg))
        else $error("hash match did not start a run");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_PATTERN)
        else $error("window fill above depth");

endmodule

`default_nettype wire

>>> hw/rtl/rkm_cell.sv
// ----------------------------------------------------------------------------
// rkm_cell: one window byte of the match chain
// Holds a byte, shifts it on to its neighbor, compares it with its pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rkm_cell
    import rkm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire byte_t      shift_in,
    input  wire byte_t      pattern_byte,
    input  wire logic       in_window,
    output byte_t           data,
    output cell_stat_t      stat
);

    byte_t data_reg;
    byte_t data_next;

    // Shift from neighbor, zero on start of text
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = ctrl.clear ? 8'd0 : shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= 8'd0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    // Hash digit and full byte compares
    assign data          = data_reg;
    assign stat.digit_ok = !in_window || (mod3(data_reg) == mod3(pattern_byte));
    assign stat.byte_eq  = (data_reg == pattern_byte);

endmodule

`default_nettype wire

>>> bench/rkm_tb_pkg.sv
// ----------------------------------------------------------------------------
// rkm_tb_pkg: match position scoreboard for the Rabin-Karp match unit
// Keeps its own copy of the text window, pattern registers and position
// counter, works out the positions each text byte should report, and checks
// every result transaction against the oldest pending position.
// ----------------------------------------------------------------------------
`default_nettype none

package rkm_tb_pkg;

    import rkm_pkg::*;

    typedef struct packed {
        logic [31:0] position;
        logic        last;
    } match_pos_t;

    class match_scoreboard;
        // Mirrored block state
        byte_t       window_q[PATTERN_BYTES];
        int unsigned fill;
        logic [31:0] position;
        cfg_len_t    len_reg;
        cfg_data_t   pat_lo;
        cfg_data_t   pat_hi;

        match_pos_t  expected_positions[$];
        int unsigned errors;
        int unsigned texts;
        int unsigned results;
        int unsigned runs;
        int unsigned settings;

        function new();
            foreach (window_q[i])
            begin
                window_q[i] = '0;
            end
            fill      = 0;
            position  = '0;
            len_reg   = 5'd1;
            pat_lo    = '0;
            pat_hi    = '0;
            errors    = 0;
            texts     = 0;
            results   = 0;
            runs      = 0;
            settings  = 0;
        endfunction

        // Register write as accepted on the configuration channel
        function void write_reg(cfg_index_t idx, cfg_data_t data);
            case (idx)
                CFG_PATTERN_LENGTH: len_reg = data[4:0];
                CFG_PATTERN_LOW:    pat_lo = data;
                CFG_PATTERN_HIGH:   pat_hi = data;
                default: ;
            endcase
            settings++;
        endfunction

        // Length in effect: zero acts as one, above capacity acts as capacity
        function int unsigned used_len();
            int unsigned l;
            l = len_reg;
            if (l == 0)
            begin
                l = 1;
            end
            if (l > PATTERN_BYTES)
            begin
                l = PATTERN_BYTES;
            end
            return l;
        endfunction

        function byte_t pattern_at(int unsigned k);
            if (k < BYTES_PER_REG)
            begin
                return pat_lo[8 * k +: 8];
            end
            return pat_hi[8 * (k - BYTES_PER_REG) +: 8];
        endfunction

        // Oldest of the last l window bytes is place 0
        function byte_t window_at(int unsigned l, int unsigned k);
            return window_q[PATTERN_BYTES - l + k];
        endfunction

        function int unsigned pending();
            return expected_positions.size();
        endfunction

        // Accepted text transaction: update the window and queue positions
        function void note_text(byte_t b, logic sot);
            int unsigned       l;
            longint unsigned   text_hash;
            longint unsigned   pat_hash;
            longint unsigned   weight;
            logic [31:0]       start;
            int unsigned       k;
            bit                more;
            match_pos_t        m;

            texts++;
            l = used_len();
            if (sot)
            begin
                foreach (window_q[i])
                begin
                    window_q[i] = '0;
                end
                fill     = 0;
                position = '0;
            end

            for (int i = 0; i < PATTERN_BYTES - 1; i++)
            begin
                window_q[i] = window_q[i + 1];
            end
            window_q[PATTERN_BYTES - 1] = b;
            if (fill < PATTERN_BYTES)
            begin
                fill++;
            end
            position = position + 32'd1;

            // Base-3 hashes of the window tail and the pattern
            text_hash = 0;
            pat_hash  = 0;
            weight    = 1;
            for (int i = 0; i < l; i++)
            begin
                text_hash += longint'(int'(window_at(l, i)) % 3) * weight;
                pat_hash  += longint'(int'(pattern_at(i)) % 3) * weight;
                weight    *= 3;
            end

            if (fill < l || text_hash != pat_hash)
            begin
                return;
            end

            // Walk the leading bytes until a mismatch or the last pattern byte
            start = position - 32'(l) + 32'd1;
            k = 0;
            forever
            begin
                more       = (k + 1 < l) && (pattern_at(k) == window_at(l, k));
                m.position = start + 32'(k);
                m.last     = !more;
                expected_positions.push_back(m);
                if (!more)
                begin
                    break;
                end
                k++;
            end
        endfunction

        // Accepted result transaction: compare with the oldest pending entry
        function void check_result(logic [31:0] pos, logic last);
            match_pos_t m;
            results++;
            if (expected_positions.size() == 0)
            begin
                $error("unexpected result: compared_position %0d, last_of_run %0b",
                       pos, last);
                errors++;
                return;
            end
            m = expected_positions.pop_front();
            if (m.last)
            begin
                runs++;
            end
            if (pos !== m.position)
            begin
                $error("compared_position mismatch: expected %0d, actual %0d",
                       m.position, pos);
                errors++;
            end
            if (last !== m.last)
            begin
                $error("last_of_run mismatch: expected %0b, actual %0b", m.last, last);
                errors++;
            end
        endfunction
    endclass

endpackage

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for rabin_karp_match_positions_unit
// Streams text bytes through the unit under several pattern settings and
// handshake pressure modes, and checks every reported match position and
// run end against a scoreboard that mirrors the window and hash logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import rkm_pkg::*;
    import rkm_tb_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 6;
    localparam int          SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 36;

    logic clk;
    logic rst_n;

    int unsigned cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    match_scoreboard sb;

    rkm_text_if   text_if();
    rkm_result_if result_if();
    rkm_cfg_if    cfg_if();

    rabin_karp_match_positions_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Watchdog
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: ready changes at the falling edge, stalls at random
    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            sb.check_result(result_if.compared_position, result_if.last_of_run);
        end
    end

    // Same base-3 digit, different byte
    function automatic byte_t same_digit(byte_t b);
        return (b >= 8'd3) ? b - 8'd3 : b + 8'd3;
    endfunction

    // One text transaction; valid stays high for a following item
    task automatic send_text(input byte_t b, input logic sot);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            text_if.valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(negedge clk);
            end
        end
        text_if.valid         <= 1'b1;
        text_if.text_byte     <= b;
        text_if.start_of_text <= sot;
        @(posedge clk);
        while (text_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.note_text(b, sot);
        @(negedge clk);
    endtask

    // Stop sending, let pending positions arrive, then let the unit settle
    task automatic drain();
        text_if.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write length and both pattern registers while the unit is idle
    task automatic write_regs(input cfg_data_t len_val, input cfg_data_t lo,
                              input cfg_data_t hi);
        cfg_data_t  vals[3];
        cfg_index_t idxs[3];
        vals = '{len_val, lo, hi};
        idxs = '{CFG_PATTERN_LENGTH, CFG_PATTERN_LOW, CFG_PATTERN_HIGH};
        for (int i = 0; i < 3; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idxs[i];
            cfg_if.data  <= vals[i];
            @(posedge clk);
            while (cfg_if.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            sb.write_reg(idxs[i], vals[i]);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Pattern copies (clean or with a hash-preserving change), noise, or a
    // copy broken by a digit-changing byte
    task automatic send_sequence(input bit narrow_noise);
        int unsigned l;
        int unsigned kind;
        int unsigned mut;
        int unsigned n;
        byte_t       b;
        l    = sb.used_len();
        kind = $urandom_range(99);
        if (kind < 55)
        begin
            mut = ($urandom_range(1) == 1) ? $urandom_range(l - 1) : l;
            for (int unsigned k = 0; k < l; k++)
            begin
                b = sb.pattern_at(k);
                if (k == mut)
                begin
                    b = same_digit(b);
                end
                send_text(b, (k == 0) && ($urandom_range(9) == 0));
            end
        end
        else if (kind < 80)
        begin
            n = $urandom_range(4, 1);
            repeat (n)
            begin
                b = narrow_noise ? byte_t'($urandom_range(7)) : byte_t'($urandom);
                send_text(b, $urandom_range(29) == 0);
            end
        end
        else
        begin
            mut = $urandom_range(l - 1);
            for (int unsigned k = 0; k < l; k++)
            begin
                b = sb.pattern_at(k);
                if (k == mut)
                begin
                    b = b ^ 8'h01;
                end
                send_text(b, 1'b0);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int unsigned len_choice[RANDOM_PHASES];
        cfg_data_t   lo;
        cfg_data_t   hi;
        int unsigned phase_start;
        bit          narrow;

        sb = new();
        len_choice = '{1, 16, 2, 31, 3, 6, 0, 11};

        rst_n                 = 1'b0;
        text_if.valid         = 1'b0;
        text_if.text_byte     = '0;
        text_if.start_of_text = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = CFG_PATTERN_LENGTH;
        cfg_if.data           = '0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset pattern (one zero byte), byte extremes
        send_text(8'h00, 1'b1);
        send_text(8'hFF, 1'b0);
        send_text(8'h01, 1'b0);
        send_text(8'h80, 1'b0);
        send_text(8'h7F, 1'b0);
        drain();

        // Directed: full run, then a run cut short by a hash-equal byte
        write_regs(64'd4, 64'h0000_0000_6463_6261, 64'h0);
        send_text(8'h78, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h63, 1'b0);
        send_text(8'h64, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h66, 1'b0);
        send_text(8'h64, 1'b0);
        drain();

        // Directed: zero length acts as one, applied to bytes already held
        write_regs(64'd0, 64'h0000_0000_0000_0064, 64'h0);
        send_text(8'h67, 1'b0);
        send_text(8'h64, 1'b0);
        drain();

        // Directed: length above capacity acts as sixteen, all-ones pattern
        write_regs(64'd31, {64{1'b1}}, {64{1'b1}});
        send_text(8'hFF, 1'b1);
        repeat (16) send_text(8'hFF, 1'b0);
        drain();

        // Random phases cycling through the idle modes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            narrow = (p % 3) != 0;
            if (p == 5)
            begin
                lo = '0;
                hi = '0;
            end
            else if (narrow)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    lo[8 * i +: 8] = byte_t'($urandom_range(5));
                    hi[8 * i +: 8] = byte_t'($urandom_range(5));
                end
            end
            else
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
            end
            write_regs(cfg_data_t'(len_choice[p]), lo, hi);
            phase_start = sb.texts;
            while (sb.texts - phase_start < PHASE_ITEMS)
            begin
                send_sequence(narrow);
            end
            drain();
        end

        $display("Covered %0d text bytes and %0d match positions in %0d runs.",
                 sb.texts, sb.results, sb.runs);
        $display("Register writes: %0d, across %0d pattern settings and four idle modes.",
                 sb.settings, RANDOM_PHASES + 4);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/rkm_pkg.sv
hw/rtl/rkm_if.sv
hw/rtl/rkm_cell.sv
hw/rtl/rabin_karp_match_positions_unit.sv
bench/rkm_tb_pkg.sv
bench/tb_top.sv
